>>> rtl/bcpe_pkg.sv
// Shared types and constants for the Bezier curve point evaluator.
// No dependencies; used by the channel interfaces and the top level.
package bcpe_pkg;

  localparam int MAX_POINTS_DEF  = 8;
  localparam int T_FRAC_BITS_DEF = 16;

  localparam int COORD_W   = 16;
  localparam int CURVE_W   = 24;
  localparam int PT_FRAC_W = 8;
  localparam int IDX_W     = 3;
  localparam int PARAM_W   = 17;
  localparam int DEG_W     = 3;

  localparam logic [DEG_W-1:0] DEG_RESET = 3'd3;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  typedef struct packed {
    logic                       op;
    logic [IDX_W-1:0]           point_index;
    logic signed [COORD_W-1:0]  point_x;
    logic signed [COORD_W-1:0]  point_y;
    logic [PARAM_W-1:0]         param_t;
  } item_t;

  typedef struct packed {
    logic signed [CURVE_W-1:0] curve_x;
    logic signed [CURVE_W-1:0] curve_y;
  } result_t;

endpackage

>>> rtl/bcpe_if.sv
// Valid/ready channel interfaces: input items, results, degree writes.
// Depends on bcpe_pkg for the payload types.
interface bcpe_item_if;
  import bcpe_pkg::*;
  logic  valid;
  logic  ready;
  item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface bcpe_result_if;
  import bcpe_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface bcpe_cfg_if;
  import bcpe_pkg::*;
  logic             valid;
  logic             ready;
  logic [DEG_W-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> rtl/bcpe_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module bcpe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/bezier_curve_point_eval_top.sv
// Bezier curve point evaluator: control point store plus De Casteljau work store.
// Load: writes one control point. Evaluate at degree n: n(n+3)/2 reads (1 at degree 0)
// through one shared interpolation pipeline, with a drain state before the last level
// when n >= 2; the result is registered in the output state, and a new item is accepted
// only when idle. Reset (rst, synchronous) clears control state and sets degree 3; point
// store contents stay undefined until loaded. Depends on bcpe_pkg, bcpe_if, bcpe_ram.
module bezier_curve_point_eval_top #(
  parameter int MAX_POINTS  = bcpe_pkg::MAX_POINTS_DEF,
  parameter int T_FRAC_BITS = bcpe_pkg::T_FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  bcpe_item_if.sink     item,
  bcpe_result_if.source result,
  bcpe_cfg_if.sink      cfg
);
  import bcpe_pkg::*;

  localparam int AW   = $clog2(MAX_POINTS);
  localparam int TW   = T_FRAC_BITS + 1;
  localparam int CW   = (TW > PARAM_W) ? TW : PARAM_W;
  localparam int DW   = CURVE_W + 1;
  localparam int PW   = DW + TW + 1;
  localparam int NMAX = MAX_POINTS - 1;
  localparam logic [CW-1:0] T_ONE = CW'(1) << T_FRAC_BITS;
  localparam logic signed [PW-1:0] HALF = PW'(1) << (T_FRAC_BITS - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RUN   = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_FLUSH = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0]       state;
  logic [DEG_W-1:0] degree;
  logic [AW-1:0]    k;
  logic [AW-1:0]    j;
  logic             first;
  logic [TW-1:0]    t_reg;

  logic             s1_vld;
  logic [AW-1:0]    s1_idx;
  logic             s1_last;
  logic             s1_src_cp;
  logic signed [CURVE_W-1:0] a_x;
  logic signed [CURVE_W-1:0] a_y;

  logic             s2_vld;
  logic [AW-1:0]    s2_idx;
  logic             s2_last;
  logic signed [CURVE_W-1:0] s2_ax;
  logic signed [CURVE_W-1:0] s2_ay;
  logic signed [PW-1:0]      s2_px;
  logic signed [PW-1:0]      s2_py;

  logic signed [CURVE_W-1:0] fin_x;
  logic signed [CURVE_W-1:0] fin_y;

  logic [2*COORD_W-1:0] cp_rdata;
  logic [2*CURVE_W-1:0] work_rdata;
  logic                 cp_we;
  logic                 cp_re;
  logic                 work_we;
  logic                 work_re;

  logic                 in_xfer;
  logic [AW-1:0]        n_clamp;
  logic [CW-1:0]        t_ext;
  logic [CW-1:0]        t_sat;

  logic signed [CURVE_W-1:0] cur_x;
  logic signed [CURVE_W-1:0] cur_y;
  logic signed [DW-1:0]      diff_x;
  logic signed [DW-1:0]      diff_y;
  logic signed [PW-1:0]      sum_x;
  logic signed [PW-1:0]      sum_y;
  logic signed [PW-1:0]      q_x;
  logic signed [PW-1:0]      q_y;
  logic signed [CURVE_W-1:0] res_x;
  logic signed [CURVE_W-1:0] res_y;
  logic                      fin_cur;
  logic                      fin_s2;
  logic                      out_free;

  assign item.ready = (state == ST_IDLE);
  assign cfg.ready  = 1'b1;
  assign in_xfer    = item.valid && item.ready;
  assign out_free   = !result.valid || result.ready;

  assign n_clamp = (int'(degree) > NMAX) ? AW'(NMAX) : AW'(degree);
  assign t_ext   = CW'(item.data.param_t);
  assign t_sat   = (t_ext > T_ONE) ? T_ONE : t_ext;

  assign cp_we   = in_xfer && (item.data.op == OP_LOAD) &&
                   (int'(item.data.point_index) < MAX_POINTS);
  assign cp_re   = (state == ST_RUN) && first;
  assign work_re = (state == ST_RUN) && !first;
  assign work_we = s2_vld && !s2_last;

  bcpe_ram #(.WIDTH(2 * COORD_W), .DEPTH(MAX_POINTS)) u_cp_ram (
    .clk   (clk),
    .we    (cp_we),
    .waddr (AW'(item.data.point_index)),
    .wdata ({item.data.point_y, item.data.point_x}),
    .re    (cp_re),
    .raddr (j),
    .rdata (cp_rdata)
  );

  bcpe_ram #(.WIDTH(2 * CURVE_W), .DEPTH(MAX_POINTS)) u_work_ram (
    .clk   (clk),
    .we    (work_we),
    .waddr (s2_idx),
    .wdata ({res_y, res_x}),
    .re    (work_re),
    .raddr (j),
    .rdata (work_rdata)
  );

  always_comb begin
    if (s1_src_cp) begin
      cur_x = {cp_rdata[COORD_W-1:0], {PT_FRAC_W{1'b0}}};
      cur_y = {cp_rdata[2*COORD_W-1:COORD_W], {PT_FRAC_W{1'b0}}};
    end else begin
      cur_x = work_rdata[CURVE_W-1:0];
      cur_y = work_rdata[2*CURVE_W-1:CURVE_W];
    end
  end

  assign diff_x = DW'(cur_x) - DW'(a_x);
  assign diff_y = DW'(cur_y) - DW'(a_y);

  // round to nearest, ties up: floor((d*t + half) / 2^F)
  assign sum_x = s2_px + HALF;
  assign sum_y = s2_py + HALF;
  assign q_x   = sum_x >>> T_FRAC_BITS;
  assign q_y   = sum_y >>> T_FRAC_BITS;
  assign res_x = s2_ax + q_x[CURVE_W-1:0];
  assign res_y = s2_ay + q_y[CURVE_W-1:0];

  assign fin_cur = s1_vld && s1_last && (s1_idx == '0);
  assign fin_s2  = s2_vld && s2_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      degree       <= DEG_RESET;
      k            <= '0;
      j            <= '0;
      first        <= 1'b0;
      s1_vld       <= 1'b0;
      s1_last      <= 1'b0;
      s2_vld       <= 1'b0;
      s2_last      <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        degree <= cfg.data;
      end

      s1_vld    <= (state == ST_RUN);
      s1_idx    <= j;
      s1_last   <= (state == ST_RUN) && (k <= AW'(1)) && (j == k);
      s1_src_cp <= first;

      s2_vld  <= s1_vld && (s1_idx != '0);
      s2_last <= s1_last;

      if ((state == ST_OUT) && out_free) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_xfer && (item.data.op == OP_EVAL)) begin
            k     <= n_clamp;
            j     <= '0;
            first <= 1'b1;
            t_reg <= TW'(t_sat);
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (j == k) begin
            if (k <= AW'(1)) begin
              state <= ST_FLUSH;
            end else begin
              k     <= k - AW'(1);
              j     <= '0;
              first <= 1'b0;
              // pass through the drain state so level 1 reads see level 2 writes
              state <= (k == AW'(2)) ? ST_DRAIN : ST_RUN;
            end
          end else begin
            j <= j + AW'(1);
          end
        end
        ST_DRAIN: begin
          state <= ST_RUN;
        end
        ST_FLUSH: begin
          if (fin_cur || fin_s2) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld) begin
      a_x <= cur_x;
      a_y <= cur_y;
    end
    s2_idx <= s1_idx - AW'(1);
    s2_ax  <= a_x;
    s2_ay  <= a_y;
    s2_px  <= $signed(diff_x) * $signed({1'b0, t_reg});
    s2_py  <= $signed(diff_y) * $signed({1'b0, t_reg});
    if (fin_cur) begin
      fin_x <= cur_x;
      fin_y <= cur_y;
    end else if (fin_s2) begin
      fin_x <= res_x;
      fin_y <= res_y;
    end
    if ((state == ST_OUT) && out_free) begin
      result.data.curve_x <= fin_x;
      result.data.curve_y <= fin_y;
    end
  end

  a_rise_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(state) == ST_OUT)
    else $error("result valid rose outside output state");

  a_final_in_flush: assert property (@(posedge clk) disable iff (rst)
    (fin_cur || fin_s2) |-> state == ST_FLUSH)
    else $error("final point produced outside flush state");

  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> j <= k)
    else $error("read index passed level size");

  a_no_work_write_idle: assert property (@(posedge clk) disable iff (rst)
    work_we |-> (state != ST_IDLE) && (state != ST_OUT))
    else $error("work store written with no evaluation in flight");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for bezier_curve_point_eval_top: loads control points, sweeps the
// curve degree and checks every curve point against a De Casteljau predictor.
// Depends on bcpe_pkg, the bcpe_if channel interfaces and the RTL top level.
module tb_top;
  import bcpe_pkg::*;

  localparam int N_POINTS       = MAX_POINTS_DEF;
  localparam int T_SHIFT        = T_FRAC_BITS_DEF;
  localparam int T_ONE          = 1 << T_SHIFT;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 60;
  localparam int PHASE_ITEMS    = 160;

  class curve_tracker;
    logic signed [COORD_W-1:0] ctrl_x [N_POINTS];
    logic signed [COORD_W-1:0] ctrl_y [N_POINTS];
    logic [DEG_W-1:0]          degree;
    result_t                   pending_points [$];
    int                        errors;

    function void clear();
      degree = DEG_RESET;
      pending_points.delete();
      errors = 0;
      for (int i = 0; i < N_POINTS; i++) begin
        ctrl_x[i] = '0;
        ctrl_y[i] = '0;
      end
    endfunction

    function longint blend(longint a, longint b, longint t);
      longint v;
      v = (b - a) * t + (longint'(1) <<< (T_SHIFT - 1));
      return a + (v >>> T_SHIFT);
    endfunction

    function result_t curve_point(logic [PARAM_W-1:0] t_raw);
      longint  px [N_POINTS];
      longint  py [N_POINTS];
      longint  t;
      int      n;
      result_t r;
      n = int'(degree);
      if (n > N_POINTS - 1) n = N_POINTS - 1;
      t = longint'(t_raw);
      if (t > T_ONE) t = T_ONE;
      for (int i = 0; i <= n; i++) begin
        px[i] = longint'(ctrl_x[i]) * 256;
        py[i] = longint'(ctrl_y[i]) * 256;
      end
      for (int k = n; k > 0; k--) begin
        for (int i = 0; i < k; i++) begin
          px[i] = blend(px[i], px[i + 1], t);
          py[i] = blend(py[i], py[i + 1], t);
        end
      end
      r.curve_x = CURVE_W'(px[0]);
      r.curve_y = CURVE_W'(py[0]);
      return r;
    endfunction

    function void note_item(item_t it);
      if (it.op == OP_LOAD) begin
        if (int'(it.point_index) < N_POINTS) begin
          ctrl_x[it.point_index] = it.point_x;
          ctrl_y[it.point_index] = it.point_y;
        end
      end else begin
        pending_points.push_back(curve_point(it.param_t));
      end
    endfunction

    function void check_point(result_t got);
      result_t want;
      if (pending_points.size() == 0) begin
        errors++;
        $error("unexpected result: curve_x %0d, curve_y %0d", got.curve_x, got.curve_y);
        return;
      end
      want = pending_points.pop_front();
      if (got.curve_x !== want.curve_x) begin
        errors++;
        $error("curve_x mismatch: expected %0d, actual %0d", want.curve_x, got.curve_x);
      end
      if (got.curve_y !== want.curve_y) begin
        errors++;
        $error("curve_y mismatch: expected %0d, actual %0d", want.curve_y, got.curve_y);
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  bcpe_item_if   item_ch ();
  bcpe_result_if result_ch ();
  bcpe_cfg_if    cfg_ch ();

  curve_tracker tracker;
  bit           tx_steady;
  bit           rx_steady;
  int           quiet_cycles;

  bezier_curve_point_eval_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int send_gap();
    if (tx_steady || $urandom_range(0, 99) < 60) return 0;
    return idle_len();
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'sh8000;
    if (r == 1) return 16'sh7fff;
    return COORD_W'($urandom);
  endfunction

  function automatic logic [PARAM_W-1:0] rand_param();
    int r;
    r = $urandom_range(0, 19);
    case (r)
      0:       return '0;
      1:       return PARAM_W'(T_ONE);
      2, 3:    return PARAM_W'($urandom_range(T_ONE + 1, (1 << PARAM_W) - 1));
      4:       return PARAM_W'($urandom_range(0, 15));
      5:       return PARAM_W'($urandom_range(T_ONE - 16, T_ONE));
      default: return PARAM_W'($urandom_range(0, T_ONE));
    endcase
  endfunction

  function automatic item_t rand_item(int load_pct);
    item_t it;
    it.op          = ($urandom_range(0, 99) < load_pct) ? OP_LOAD : OP_EVAL;
    it.point_index = IDX_W'($urandom_range(0, N_POINTS - 1));
    it.point_x     = rand_coord();
    it.point_y     = rand_coord();
    it.param_t     = rand_param();
    return it;
  endfunction

  function automatic item_t load_item(int idx, int x, int y);
    item_t it;
    it             = '0;
    it.op          = OP_LOAD;
    it.point_index = IDX_W'(idx);
    it.point_x     = COORD_W'(x);
    it.point_y     = COORD_W'(y);
    it.param_t     = rand_param();
    return it;
  endfunction

  function automatic item_t eval_item(int t);
    item_t it;
    it             = '0;
    it.op          = OP_EVAL;
    it.point_index = IDX_W'($urandom_range(0, N_POINTS - 1));
    it.point_x     = rand_coord();
    it.point_y     = rand_coord();
    it.param_t     = PARAM_W'(t);
    return it;
  endfunction

  task automatic send_item(item_t it, int gap);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.data  <= it;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_points.size() != 0) @(posedge clk);
  endtask

  task automatic write_degree(logic [DEG_W-1:0] d);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // result side: random stalls unless held steady
  initial begin
    int stall_left;
    stall_left = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        result_ch.ready <= 1'b0;
        stall_left--;
      end else if (!rx_steady && $urandom_range(0, 99) < 20) begin
        stall_left = idle_len() - 1;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) tracker.check_point(result_ch.data);
      if (item_ch.valid && item_ch.ready) tracker.note_item(item_ch.data);
      if (cfg_ch.valid && cfg_ch.ready) tracker.degree = cfg_ch.data;
    end
  end

  always @(posedge clk) begin
    if (rst || (result_ch.valid && result_ch.ready) || (item_ch.valid && item_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    int dir_x [N_POINTS];
    int dir_y [N_POINTS];
    int deg3_t [7];
    int deg7_t [4];
    logic [DEG_W-1:0] phase_deg [8];
    tracker = new();
    tracker.clear();
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    dir_x  = '{-32768, 32767, 0, -1, 12345, -20000, 32767, -32768};
    dir_y  = '{32767, -32768, -1, 0, -32768, 32767, 1, -32768};
    deg3_t = '{0, 65536, 32768, 1, 65535, 65537, 131071};
    deg7_t = '{0, 32768, 65536, 131071};
    phase_deg = '{3'd1, 3'd7, 3'd2, 3'd5, 3'd0, 3'd6, 3'd4, 3'd3};
    rst           <= 1'b1;
    item_ch.valid <= 1'b0;
    item_ch.data  <= '0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.data   <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // fill the whole store before any evaluate
    for (int i = 0; i < N_POINTS; i++) send_item(load_item(i, dir_x[i], dir_y[i]), 0);
    foreach (deg3_t[i]) send_item(eval_item(deg3_t[i]), send_gap());
    write_degree(3'd7);
    foreach (deg7_t[i]) send_item(eval_item(deg7_t[i]), send_gap());
    write_degree(3'd0);
    send_item(eval_item(21845), 0);
    send_item(eval_item(65536), 0);
    write_degree(3'd1);
    send_item(eval_item(32768), 0);
    send_item(eval_item(131071), 0);

    foreach (phase_deg[ph]) begin
      write_degree(phase_deg[ph]);
      tx_steady = (ph == 2 || ph == 5);
      rx_steady = (ph == 3 || ph == 5);
      for (int j = 0; j < PHASE_ITEMS; j++) begin
        if (j == PHASE_ITEMS / 2 || $urandom_range(0, 99) == 0) drain();
        send_item(rand_item(35), send_gap());
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending_points.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
